/* rtl/edf_pkg.sv */
// Shared types, constants and state codes for the EDF periodic dispatcher.
`default_nettype none

package edf_pkg;

   // default job count, handed to the top level parameter
   localparam int JOB_COUNT_DEF = 5;

   // field widths
   localparam int NOW_W      = 63;
   localparam int DEADLINE_W = 64;
   localparam int PERIOD_W   = 32;
   localparam int TOL_W      = 16;
   localparam int JOB_W      = 3;
   localparam int LATE_W     = 16;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = CSR_IDX_W'(1);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(200000);
   localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(5);

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // lateness in ms: anything at or above 65536 ms saturates; below that the
   // difference fits in 26 bits and divides by 1000 via reciprocal multiply
   localparam int US_PER_MS  = 1000;
   localparam int SMALL_W    = 26;
   localparam logic [DEADLINE_W-1:0] LATE_SAT_US = DEADLINE_W'(65536 * US_PER_MS);
   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);  // ceil(2^36 / 1000)
   localparam int PROD_W      = SMALL_W + RECIP_W;
   localparam logic [LATE_W-1:0] LATE_MAX = '1;

   // input word
   typedef struct packed {
      logic             command;
      logic [NOW_W-1:0] now_us;
   } req_type;

   // result word
   typedef struct packed {
      logic              dispatched;
      logic [JOB_W-1:0]  job_number;
      logic              deadline_missed;
      logic [LATE_W-1:0] lateness_ms;
   } rsp_type;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_START_ADD = 8'b0000_0010,
      ST_START_WR  = 8'b0000_0100,
      ST_TICK_RD   = 8'b0000_1000,
      ST_SCAN      = 8'b0001_0000,
      ST_LATE      = 8'b0010_0000,
      ST_RANGE     = 8'b0100_0000,
      ST_ADV       = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

/* rtl/edf_periodic_dispatcher.sv */
// Top level of the EDF periodic dispatcher: deadline memory, shared adder and sequencer.
//
// Keeps one 64-bit deadline per job in a small memory. A start word does one
// add, then one memory write per job, before its result. A tick word does one
// read per job through the single memory read port, which sets the scan length;
// then the lateness subtract, the saturation check with the divide-by-1000
// multiply, and the deadline advance follow in turn. A tick with nothing due
// ends after the subtract. busy is high from the cycle after accept until the
// result strobe; rsp_valid pulses for one cycle and cannot be held off, so the
// receiver must take the word in that cycle. Configuration writes are always
// ready and should only be made while busy is low.
`default_nettype none

module edf_periodic_dispatcher
   import edf_pkg::*;
#(
   parameter int JOB_COUNT = JOB_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOB_COUNT - 1);

   // registers and next values
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic [NOW_W-1:0]        now_ff, now_in;
   logic [DEADLINE_W-1:0]   work_ff, work_in;
   logic [DEADLINE_W-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic                    big_ff, big_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [PERIOD_W-1:0]     period_ff;
   logic [TOL_W-1:0]        tol_ff;
   logic [JOB_COUNT-1:0]    valid_ff, valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DEADLINE_W-1:0]   rd_data_ff;
   logic                    rd_valid_ff;

   // deadline memory
   logic [DEADLINE_W-1:0]   deadline_mem [JOB_COUNT];
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [DEADLINE_W-1:0]   mem_wdata;
   logic                    mem_re;
   logic [IDX_W-1:0]        mem_raddr;

   // shared add / subtract unit
   logic [DEADLINE_W-1:0]   alu_a, alu_b;
   logic                    alu_sub;
   logic [DEADLINE_W:0]     alu_res;
   logic                    alu_carry;
   logic [DEADLINE_W-1:0]   alu_sat;

   logic                    accept;
   logic [DEADLINE_W-1:0]   cand;
   logic [LATE_W-1:0]       quot;
   logic [IDX_W+3:0]        job_sum;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an entry never written reads as zero
   assign cand    = rd_valid_ff ? rd_data_ff : '0;
   assign quot    = prod_ff[RECIP_SHIFT +: LATE_W];
   assign job_sum = (IDX_W+4)'(best_idx_ff) + (IDX_W+4)'(1);

   // operand select for the shared unit
   always_comb begin
      alu_a   = best_ff;
      alu_b   = DEADLINE_W'(period_ff);
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_START_ADD: begin
            alu_a = DEADLINE_W'(now_ff);
         end
         ST_SCAN: begin
            alu_a   = cand;
            alu_b   = best_ff;
            alu_sub = 1'b1;
         end
         ST_LATE: begin
            alu_a   = DEADLINE_W'(now_ff);
            alu_b   = best_ff;
            alu_sub = 1'b1;
         end
         ST_RANGE: begin
            alu_a   = work_ff;
            alu_b   = LATE_SAT_US;
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // carry out on add means overflow, on subtract means borrow (a < b)
   assign alu_res   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_carry = alu_res[DEADLINE_W];
   assign alu_sat   = alu_carry ? '1 : alu_res[DEADLINE_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      now_in       = now_ff;
      work_in      = work_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      big_in       = big_ff;
      prod_in      = prod_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = work_ff;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req_data.now_us;
               cnt_in = '0;
               state_in = (req_data.command == CMD_START) ? ST_START_ADD : ST_TICK_RD;
            end
         end
         // now + period, computed once for all jobs
         ST_START_ADD: begin
            work_in  = alu_sat;
            state_in = ST_START_WR;
         end
         // write one entry per cycle
         ST_START_WR: begin
            mem_we = 1'b1;
            valid_in[cnt_ff] = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TICK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_SCAN;
         end
         // compare entry cnt while reading the next one; strict less keeps lowest index
         ST_SCAN: begin
            if ((cnt_ff == '0) || alu_carry) begin
               best_in     = cand;
               best_idx_in = cnt_ff;
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_LATE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cnt_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         // now - best; a borrow means nothing is due
         ST_LATE: begin
            work_in = alu_res[DEADLINE_W-1:0];
            if (alu_carry) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_RANGE;
            end
         end
         // saturation check and reciprocal multiply for the ms count
         ST_RANGE: begin
            big_in   = !alu_carry;
            prod_in  = PROD_W'(work_ff[SMALL_W-1:0]) * PROD_W'(RECIP);
            state_in = ST_ADV;
         end
         // advance the deadline and report
         ST_ADV: begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff;
            mem_wdata = alu_sat;
            valid_in[best_idx_ff] = 1'b1;
            rsp_in.dispatched      = 1'b1;
            rsp_in.job_number      = job_sum[JOB_W-1:0];
            rsp_in.deadline_missed = big_ff || (quot > tol_ff);
            rsp_in.lateness_ms     = big_ff ? LATE_MAX : quot;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
         tol_ff       <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PERIOD) begin
               period_ff <= csr_wdata[PERIOD_W-1:0];
            end else if (csr_index == CSR_TOLERANCE) begin
               tol_ff <= csr_wdata[TOL_W-1:0];
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      now_ff      <= now_in;
      work_ff     <= work_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      big_ff      <= big_in;
      prod_ff     <= prod_in;
      rsp_ff      <= rsp_in;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[mem_waddr] <= mem_wdata;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff  <= deadline_mem[mem_raddr];
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/edf_checker.sv */
// Port-level assertions for the EDF periodic dispatcher, bound to the top level.
`default_nettype none

module edf_checker
   import edf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire rsp_type rsp_data,
   input wire logic    rsp_valid
);

   // an accepted word keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a result is shown only once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // one strobe per word, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // an empty result carries all-zero fields
   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.dispatched) |->
         (rsp_data.job_number == '0 && rsp_data.lateness_ms == '0 &&
          !rsp_data.deadline_missed))
      else $error("non-dispatch result with nonzero fields");

   // a dispatch names a job
   a_rsp_job: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dispatched) |-> (rsp_data.job_number != '0))
      else $error("dispatch with job number zero");

endmodule

bind edf_periodic_dispatcher edf_checker u_edf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

/* test/tb_edf_periodic_dispatcher.sv */
// Self-checking testbench for the EDF periodic dispatcher: predicted vs. observed result words.
`timescale 1ns / 100ps

module tb_edf_periodic_dispatcher;
   import edf_pkg::*;

   localparam int NJOBS = JOB_COUNT_DEF;
   localparam logic [63:0] NOW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * (NJOBS + 5) + 4;
   localparam int WORDS_PER_PHASE = 150;
   localparam int PHASES = 8;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state: deadlines and the register copies
   logic [63:0] next_deadline [NJOBS];
   logic [PERIOD_W-1:0] period_cfg;
   logic [TOL_W-1:0] tol_cfg;

   req_type cmd_backlog[$];
   rsp_type due_results[$];

   int cycle_count = 0;
   int fault_count = 0;
   int words_seen = 0;
   int dispatch_seen = 0;
   int missed_seen = 0;
   int saturated_seen = 0;

   edf_periodic_dispatcher dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // deadline advance, pinned at all ones instead of wrapping
   function automatic logic [63:0] deadline_plus_period(input logic [63:0] base);
      logic [64:0] sum;
      sum = {1'b0, base} + 65'(period_cfg);
      return sum[64] ? '1 : sum[63:0];
   endfunction

   // EDF pick for one command word; updates the deadline table
   function automatic rsp_type edf_dispatch(input req_type w);
      rsp_type r;
      int pick;
      logic [63:0] now;
      logic [63:0] late_ms;
      r = '0;
      now = {1'b0, w.now_us};
      if (w.command == CMD_START) begin
         for (int j = 0; j < NJOBS; j++) next_deadline[j] = deadline_plus_period(now);
         return r;
      end
      pick = 0;
      for (int j = 1; j < NJOBS; j++)
         if (next_deadline[j] < next_deadline[pick]) pick = j;
      if (now >= next_deadline[pick]) begin
         late_ms = (now - next_deadline[pick]) / US_PER_MS;
         r.dispatched = 1'b1;
         r.job_number = JOB_W'(pick + 1);
         r.deadline_missed = (late_ms > 64'(tol_cfg));
         r.lateness_ms = (late_ms > 64'(LATE_MAX)) ? LATE_MAX : late_ms[LATE_W-1:0];
         next_deadline[pick] = deadline_plus_period(next_deadline[pick]);
      end
      return r;
   endfunction

   function automatic logic [63:0] rand_below(input logic [63:0] lim);
      return {$urandom, $urandom} % (lim + 64'd1);
   endfunction

   task automatic push_word(input logic cmd, input logic [63:0] t);
      req_type w;
      w.command = cmd;
      w.now_us = t[NOW_W-1:0];
      cmd_backlog.push_back(w);
   endtask

   // write one register; the handshake completes at the edge where ready is seen
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PERIOD) period_cfg = val[PERIOD_W-1:0];
      else if (idx == CSR_TOLERANCE) tol_cfg = val[TOL_W-1:0];
   endtask

   // settle on the falling edge so queue updates of the rising edge are visible
   task automatic wait_idle;
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || start || due_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly monotonic time after a start, with restarts, noise and backward steps
   task automatic queue_random_phase(input int count);
      logic [63:0] cursor;
      logic [63:0] base;
      logic [63:0] step;
      int roll;
      base = (period_cfg < 5000) ? 64'd5000 : 64'(period_cfg);
      cursor = ($urandom_range(0, 3) == 0) ? rand_below(NOW_MAX >> 1) + (NOW_MAX >> 1)
                                           : rand_below(64'h0000_00FF_FFFF_FFFF);
      push_word(CMD_START, cursor);
      for (int n = 1; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            push_word(CMD_START, cursor);
         end else if (roll < 7) begin
            cursor = rand_below(NOW_MAX);
            push_word(CMD_START, cursor);
         end else if (roll < 12) begin
            push_word(CMD_TICK, rand_below(NOW_MAX));
         end else if (roll < 15) begin
            push_word(CMD_TICK, cursor - rand_below((cursor < base) ? cursor : base));
         end else begin
            if (roll < 85) step = rand_below(base * 2 / 5);
            else if (roll < 96) step = rand_below(base);
            else step = rand_below(64'd80_000_000);
            cursor = cursor + step;
            if (cursor > NOW_MAX) begin
               cursor = rand_below(64'hFFFF_FFFF);
               push_word(CMD_START, cursor);
            end else begin
               push_word(CMD_TICK, cursor);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   // driver: issue command words from the backlog with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) due_results.push_back(edf_dispatch(req_data));
         if (!start || !busy) begin
            if (cmd_backlog.size() != 0 &&
                ((cycle_count % 5000) < 700 || $urandom_range(0, 99) >= 27)) begin
               start <= 1'b1;
               req_data <= cmd_backlog.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed result word against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h", $time, rsp_data);
            fault_count++;
         end else begin
            want = due_results.pop_front();
            check_field("dispatched", 16'(want.dispatched), 16'(rsp_data.dispatched));
            check_field("job_number", 16'(want.job_number), 16'(rsp_data.job_number));
            check_field("deadline_missed", 16'(want.deadline_missed),
                        16'(rsp_data.deadline_missed));
            check_field("lateness_ms", want.lateness_ms, rsp_data.lateness_ms);
            if (want.dispatched) dispatch_seen++;
            if (want.deadline_missed) missed_seen++;
            if (want.lateness_ms == LATE_MAX) saturated_seen++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding", cycle_count,
                  due_results.size() + cmd_backlog.size());
         $display("FAIL edf_periodic_dispatcher");
         $finish;
      end
   end

   initial begin : stimulus
      logic [PERIOD_W-1:0] phase_period [PHASES];
      logic [TOL_W-1:0] phase_tol [PHASES];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      period_cfg = PERIOD_RESET;
      tol_cfg = TOL_RESET;
      for (int j = 0; j < NJOBS; j++) next_deadline[j] = '0;

      // register settings, extremes first
      phase_period[0] = '0;             phase_tol[0] = '1;
      phase_period[1] = PERIOD_W'(1);   phase_tol[1] = '0;
      phase_period[2] = '1;             phase_tol[2] = '0;
      phase_period[3] = PERIOD_W'(200000); phase_tol[3] = '1;
      for (int p = 4; p < PHASES; p++) begin
         phase_period[p] = PERIOD_W'($urandom_range(1000, 40000));
         phase_tol[p] = TOL_W'($urandom_range(0, 20));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ticks before any start, tie order, tolerance edge,
      // no-dispatch tick, saturation at and past 65535 ms, extreme times
      push_word(CMD_TICK, 64'd0);
      push_word(CMD_TICK, 64'd1999);
      push_word(CMD_TICK, 64'd7000);
      push_word(CMD_TICK, 64'd6000);
      push_word(CMD_TICK, 64'd5999);
      push_word(CMD_TICK, 64'd199999);
      push_word(CMD_TICK, 64'd200000);
      push_word(CMD_TICK, NOW_MAX);
      push_word(CMD_START, NOW_MAX);
      push_word(CMD_TICK, NOW_MAX);
      push_word(CMD_START, 64'd0);
      push_word(CMD_TICK, 64'd65735999);
      push_word(CMD_TICK, 64'd65736000);
      push_word(CMD_TICK, 64'h5555_5555_5555_5555);
      push_word(CMD_TICK, 64'h2AAA_AAAA_AAAA_AAAA);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         csr_write(CSR_PERIOD, CSR_DATA_W'(phase_period[p]));
         csr_write(CSR_TOLERANCE, {16'($urandom), phase_tol[p]});
         csr_write(CSR_IDX_W'($urandom_range(2, 15)), $urandom);
         if (p == 0) begin
            // zero period keeps job 1 due; widest tolerance against saturated lateness
            push_word(CMD_START, 64'd0);
            push_word(CMD_TICK, 64'd0);
            push_word(CMD_TICK, 64'd0);
            push_word(CMD_TICK, 64'd65535999);
            push_word(CMD_TICK, 64'd65536000);
         end
         queue_random_phase(WORDS_PER_PHASE);
         wait_idle();
      end

      $display("Checked %0d result words over %0d register settings and reset defaults.",
               words_seen, PHASES);
      $display("%0d dispatches, %0d missed deadlines, %0d saturated lateness values.",
               dispatch_seen, missed_seen, saturated_seen);
      if (fault_count == 0) begin
         $display("PASS edf_periodic_dispatcher");
      end else begin
         $display("FAIL edf_periodic_dispatcher");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/edf_pkg.sv
rtl/edf_periodic_dispatcher.sv
rtl/edf_checker.sv
test/tb_edf_periodic_dispatcher.sv
